### hw/rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the sorted priority queue: operation and error
// codes, the stored entry layout and the input and result words.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int PRIO_W = 16;
	localparam int TIME_W = 16;
	localparam int ID_W   = 8;
	localparam int CNT_W  = 5;

	localparam logic [PRIO_W-1:0] PRIO_MAX = '1;

	// operation codes
	localparam logic [1:0] OP_PUSH   = 2'd0;
	localparam logic [1:0] OP_POP    = 2'd1;
	localparam logic [1:0] OP_UPDATE = 2'd2;

	// error codes
	localparam logic [1:0] ERR_NONE  = 2'd0;
	localparam logic [1:0] ERR_FULL  = 2'd1;
	localparam logic [1:0] ERR_EMPTY = 2'd2;

	// one stored task
	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [PRIO_W-1:0] prio;
		logic [TIME_W-1:0] etime;
		logic [TIME_W-1:0] rtime;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// input word
	typedef struct packed {
		logic [1:0]        op;
		logic [ID_W-1:0]   task_id;
		logic [PRIO_W-1:0] new_priority;
		logic [TIME_W-1:0] exec_time;
		logic [TIME_W-1:0] remaining_time;
		logic [TIME_W-1:0] time_now;
	} in_item_t;

	// result word
	typedef struct packed {
		logic              head_valid;
		logic [ID_W-1:0]   head_task;
		logic [PRIO_W-1:0] head_priority;
		logic [CNT_W-1:0]  entry_count;
		logic [1:0]        error;
	} out_item_t;

endpackage

### hw/rtl/sorted_priority_queue_with_aging.sv
// An update in which any entry ages is followed by a stable insertion re-sort
// when the queue holds more than one entry.
// Every operation ends with a head read from the entry RAM.
// The block takes one word at a time; the sequencer walks the simple dual-port
// entry RAM one entry at a time. A new word may be taken while a result waits.
// Reset clears the count, the sequencer and the output valid flag; desc_q is 1.
// ----------------------------------------------------------------------------
// sorted_priority_queue_with_aging
// Bounded task queue kept stably sorted by priority, with aging updates.
// Entries live in a RAM; a small sequencer scans, shifts and re-inserts them
// through one shared compare and aging unit.
// ----------------------------------------------------------------------------
module sorted_priority_queue_with_aging #(
	parameter int DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  spq_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output spq_pkg::out_item_t out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_data
);
	import spq_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

	typedef enum logic [13:0] {
		ST_IDLE      = 14'b00000000000001,
		ST_POP_RD    = 14'b00000000000010,
		ST_POP_WR    = 14'b00000000000100,
		ST_AGE_RD    = 14'b00000000001000,
		ST_AGE_WR    = 14'b00000000010000,
		ST_LOAD_RD   = 14'b00000000100000,
		ST_LOAD_WAIT = 14'b00000001000000,
		ST_SCAN_RD   = 14'b00000010000000,
		ST_SCAN_CHK  = 14'b00000100000000,
		ST_SHIFT_RD  = 14'b00001000000000,
		ST_SHIFT_WR  = 14'b00010000000000,
		ST_PLACE     = 14'b00100000000000,
		ST_HEAD_RD   = 14'b01000000000000,
		ST_HEAD_WAIT = 14'b10000000000000
	} state_t;

	state_t              state_q;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       idx_q;
	logic [CW-1:0]       ri_q;
	logic [CW-1:0]       n_q;
	logic [CW-1:0]       pos_q;
	entry_t              elem_q;
	logic [TIME_W-1:0]   time_q;
	logic [1:0]          err_q;
	logic                hit_q;
	logic                resort_q;
	logic                desc_q;
	out_item_t           out_q;
	logic                out_valid_q;

	logic                rd_en;
	logic [AW-1:0]       rd_addr;
	logic                wr_en;
	logic [AW-1:0]       wr_addr;
	entry_t              wr_data;
	entry_t              rd_data;
	logic [CW-1:0]       idx_dec;
	logic                ahead;
	logic [PRIO_W-1:0]   aged;
	logic                match;
	logic                in_fire;
	logic                out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid & in_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign out_free  = ~out_valid_q | out_ready;
	assign idx_dec   = idx_q - CW'(1);

	// entry store
	spq_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// shared compare / aging unit
	spq_alu u_alu (
		.desc    (desc_q),
		.key_old (rd_data.prio),
		.key_new (elem_q.prio),
		.etime   (rd_data.etime),
		.rtime   (rd_data.rtime),
		.time_now(time_q),
		.ahead   (ahead),
		.aged    (aged),
		.match   (match)
	);

	// ram port control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = rd_data;
		case (state_q)
			ST_POP_RD: begin
				rd_en   = (idx_q < count_q);
				rd_addr = idx_q[AW-1:0];
			end
			ST_POP_WR: begin
				wr_en   = 1'b1;
				wr_addr = idx_dec[AW-1:0];
			end
			ST_AGE_RD: begin
				rd_en   = (idx_q < count_q);
				rd_addr = idx_q[AW-1:0];
			end
			ST_AGE_WR: begin
				wr_en        = 1'b1;
				wr_addr      = idx_q[AW-1:0];
				wr_data.prio = aged;
			end
			ST_LOAD_RD: begin
				rd_en   = (ri_q < count_q);
				rd_addr = ri_q[AW-1:0];
			end
			ST_SCAN_RD: begin
				rd_en   = (idx_q < n_q);
				rd_addr = idx_q[AW-1:0];
			end
			ST_SHIFT_RD: begin
				rd_en   = (idx_q != pos_q);
				rd_addr = idx_dec[AW-1:0];
			end
			ST_SHIFT_WR: begin
				wr_en   = 1'b1;
				wr_addr = idx_q[AW-1:0];
			end
			ST_PLACE: begin
				wr_en   = 1'b1;
				wr_addr = pos_q[AW-1:0];
				wr_data = elem_q;
			end
			ST_HEAD_RD: begin
				rd_en   = 1'b1;
				rd_addr = '0;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			desc_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			desc_q <= cfg_data;
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_HEAD_WAIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			ri_q        <= '0;
			n_q         <= '0;
			pos_q       <= '0;
			err_q       <= ERR_NONE;
			hit_q       <= 1'b0;
			resort_q    <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						err_q    <= ERR_NONE;
						resort_q <= 1'b0;
						hit_q    <= 1'b0;
						idx_q    <= '0;
						time_q   <= in_data.time_now;
						elem_q   <= '{id: in_data.task_id, prio: in_data.new_priority,
							etime: in_data.exec_time, rtime: in_data.remaining_time};
						case (in_data.op)
							OP_PUSH: begin
								if (count_q == DEPTH_C) begin
									err_q   <= ERR_FULL;
									state_q <= ST_HEAD_RD;
								end else begin
									n_q     <= count_q;
									state_q <= ST_SCAN_RD;
								end
							end
							OP_POP: begin
								if (count_q == '0) begin
									err_q   <= ERR_EMPTY;
									state_q <= ST_HEAD_RD;
								end else begin
									idx_q   <= CW'(1);
									state_q <= ST_POP_RD;
								end
							end
							OP_UPDATE: begin
								state_q <= (count_q == '0) ? ST_HEAD_RD : ST_AGE_RD;
							end
							default: begin
								state_q <= ST_HEAD_RD;
							end
						endcase
					end
				end
				// pop: move every entry after the head down one slot
				ST_POP_RD: begin
					if (idx_q < count_q) begin
						state_q <= ST_POP_WR;
					end else begin
						count_q <= count_q - CW'(1);
						state_q <= ST_HEAD_RD;
					end
				end
				ST_POP_WR: begin
					idx_q   <= idx_q + CW'(1);
					state_q <= ST_POP_RD;
				end
				// aging pass over all entries
				ST_AGE_RD: begin
					if (idx_q < count_q) begin
						state_q <= ST_AGE_WR;
					end else if (hit_q && count_q > CW'(1)) begin
						ri_q     <= CW'(1);
						resort_q <= 1'b1;
						state_q  <= ST_LOAD_RD;
					end else begin
						state_q <= ST_HEAD_RD;
					end
				end
				ST_AGE_WR: begin
					hit_q   <= hit_q | match;
					idx_q   <= idx_q + CW'(1);
					state_q <= ST_AGE_RD;
				end
				// re-sort: insert entry ri into the sorted prefix below it
				ST_LOAD_RD: begin
					state_q <= (ri_q < count_q) ? ST_LOAD_WAIT : ST_HEAD_RD;
				end
				ST_LOAD_WAIT: begin
					elem_q  <= rd_data;
					n_q     <= ri_q;
					idx_q   <= '0;
					state_q <= ST_SCAN_RD;
				end
				// find the first entry that the new word goes ahead of
				ST_SCAN_RD: begin
					if (idx_q < n_q) begin
						state_q <= ST_SCAN_CHK;
					end else begin
						pos_q   <= n_q;
						idx_q   <= n_q;
						state_q <= ST_SHIFT_RD;
					end
				end
				ST_SCAN_CHK: begin
					if (ahead) begin
						pos_q   <= idx_q;
						idx_q   <= n_q;
						state_q <= ST_SHIFT_RD;
					end else begin
						idx_q   <= idx_q + CW'(1);
						state_q <= ST_SCAN_RD;
					end
				end
				// open a gap at the insert position, tail first
				ST_SHIFT_RD: begin
					state_q <= (idx_q != pos_q) ? ST_SHIFT_WR : ST_PLACE;
				end
				ST_SHIFT_WR: begin
					idx_q   <= idx_dec;
					state_q <= ST_SHIFT_RD;
				end
				ST_PLACE: begin
					if (resort_q) begin
						ri_q    <= ri_q + CW'(1);
						state_q <= ST_LOAD_RD;
					end else begin
						count_q <= count_q + CW'(1);
						state_q <= ST_HEAD_RD;
					end
				end
				ST_HEAD_RD: begin
					state_q <= ST_HEAD_WAIT;
				end
				// build the result word once the output register is free
				ST_HEAD_WAIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result word, payload only
	always_ff @(posedge clk) begin
		if (state_q == ST_HEAD_WAIT && out_free) begin
			out_q.head_valid    <= (count_q != '0);
			out_q.head_task     <= (count_q != '0) ? rd_data.id : '0;
			out_q.head_priority <= (count_q != '0) ? rd_data.prio : '0;
			out_q.entry_count   <= CNT_W'(count_q);
			out_q.error         <= err_q;
		end
	end

endmodule

### hw/rtl/spq_ram.sv
// ----------------------------------------------------------------------------
// spq_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module spq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                             clk,
	input  logic                             wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                 wr_data,
	input  logic                             rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                 rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

### hw/rtl/spq_alu.sv
// ----------------------------------------------------------------------------
// spq_alu
// Shared key unit: the ordering compare used by insertion and the
// saturating aging multiply used by updates.
// ----------------------------------------------------------------------------
module spq_alu (
	input  logic                       desc,
	input  logic [spq_pkg::PRIO_W-1:0] key_old,
	input  logic [spq_pkg::PRIO_W-1:0] key_new,
	input  logic [spq_pkg::TIME_W-1:0] etime,
	input  logic [spq_pkg::TIME_W-1:0] rtime,
	input  logic [spq_pkg::TIME_W-1:0] time_now,
	output logic                       ahead,
	output logic [spq_pkg::PRIO_W-1:0] aged,
	output logic                       match
);
	import spq_pkg::*;

	logic              e_hit;
	logic              r_hit;
	logic [PRIO_W-1:0] p_x4;

	// new key goes ahead of the stored one
	assign ahead = desc ? (key_old < key_new) : (key_old > key_new);

	// aging: x4 on exec time hit, then x2 on remaining time hit, saturating
	assign e_hit = (etime == time_now);
	assign r_hit = (rtime == time_now);

	always_comb begin
		p_x4 = key_old;
		if (e_hit) begin
			p_x4 = (key_old[PRIO_W-1 -: 2] != 2'b00) ? PRIO_MAX : {key_old[PRIO_W-3:0], 2'b00};
		end
		aged = p_x4;
		if (r_hit) begin
			aged = p_x4[PRIO_W-1] ? PRIO_MAX : {p_x4[PRIO_W-2:0], 1'b0};
		end
	end

	assign match = e_hit | r_hit;

endmodule

### hw/rtl/spq_chk.sv
// ----------------------------------------------------------------------------
// spq_chk
// Port-level checks for the sorted priority queue, bound to the top level.
// ----------------------------------------------------------------------------
module spq_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input spq_pkg::out_item_t out_data
);
	import spq_pkg::*;

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result word changed while stalled");

	// the block is busy right after taking a word
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted twice in a row");

	// an empty queue reports a zero head
	a_empty_head: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.head_valid |->
			out_data.head_task == '0 && out_data.head_priority == '0)
		else $error("empty queue reports a head");

	// a dropped push means the queue holds entries
	a_full_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.error == ERR_FULL |-> out_data.head_valid)
		else $error("full error with empty queue");

	// a pop on empty leaves the queue empty
	a_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.error == ERR_EMPTY |->
			!out_data.head_valid && out_data.entry_count == '0)
		else $error("empty error with entries present");

endmodule

bind sorted_priority_queue_with_aging spq_chk u_spq_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_data (out_data)
);
